[rtl/rmcf_pkg.sv]
// Shared types and constants of the RIFF metadata chunk filter.
`timescale 1ns / 1ps
`default_nettype none
package rmcf_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_FILE_LENGTH = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_STRIP_EXIF  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_STRIP_XMP   = 2'd2;

  // Data bytes carried by one command
  localparam logic [3:0] LEN_NONE      = 4'd0;
  localparam logic [3:0] LEN_BYTE      = 4'd1;
  localparam logic [3:0] LEN_CHUNK_HDR = 4'd8;
  localparam logic [3:0] LEN_FILE_HDR  = 4'd12;

  // Four-character codes, first character in the low byte
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WEBP = 32'h5042_4557;
  localparam logic [31:0] TAG_EXIF = 32'h4649_5845;
  localparam logic [31:0] TAG_XMP  = 32'h2050_4D58;

  typedef enum logic [2:0] {
    MODE_FILE_HDR,
    MODE_CHUNK_HDR,
    MODE_PAYLOAD,
    MODE_TRAIL,
    MODE_DONE
  } mode_e;

  typedef struct packed {
    logic [3:0]       n_data;
    logic [11:0][7:0] data;
    logic             has_end;
    logic             status;
    logic [31:0]      total;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_req_t;

endpackage
`default_nettype wire

[rtl/rmcf_front.sv]
// Front end: accept bytes, track the RIFF structure, issue output commands.
`timescale 1ns / 1ps
`default_nettype none
module rmcf_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [rmcf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [31:0]                   cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [7:0]                    in_byte_i,
  input  wire logic                          q_full_i,
  output rmcf_pkg::cmd_req_t                 push_o
);

  logic [31:0]      file_length_q;
  logic             strip_exif_q, strip_xmp_q;
  logic [31:0]      pos_q, pos_d;
  logic [11:0][7:0] hdr_q;
  logic [3:0]       fill_q, fill_d;
  logic [32:0]      rem_q, rem_d;
  rmcf_pkg::mode_e  mode_q, mode_d;
  logic             keep_q, keep_d;
  logic [31:0]      emitted_q, emitted_d;

  logic             accept;
  logic             hdr_we;
  logic [3:0]       hdr_idx;
  logic [31:0]      pos_next;
  logic [31:0]      clen;
  logic [32:0]      padded;
  logic             overrun;
  logic             keep_new;
  logic [32:0]      rem_dec;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign pos_next   = pos_q + 32'd1;
  assign clen       = {in_byte_i, hdr_q[6], hdr_q[5], hdr_q[4]};
  assign padded     = {1'b0, clen} + {32'd0, clen[0]};
  assign overrun    = ({2'b00, pos_q} + 34'd1 + {1'b0, padded}) > {2'b00, file_length_q};
  assign keep_new   = !((hdr_q[3:0] == rmcf_pkg::TAG_EXIF) && strip_exif_q) &&
                      !((hdr_q[3:0] == rmcf_pkg::TAG_XMP) && strip_xmp_q);
  assign rem_dec    = (rem_q == 33'd0) ? 33'd0 : rem_q - 33'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_length_q <= '0;
      strip_exif_q  <= 1'b0;
      strip_xmp_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        rmcf_pkg::CFG_FILE_LENGTH: file_length_q <= cfg_data_i;
        rmcf_pkg::CFG_STRIP_EXIF:  strip_exif_q  <= cfg_data_i[0];
        rmcf_pkg::CFG_STRIP_XMP:   strip_xmp_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      fill_q    <= '0;
      rem_q     <= '0;
      mode_q    <= rmcf_pkg::MODE_FILE_HDR;
      keep_q    <= 1'b0;
      emitted_q <= '0;
    end else begin
      pos_q     <= pos_d;
      fill_q    <= fill_d;
      rem_q     <= rem_d;
      mode_q    <= mode_d;
      keep_q    <= keep_d;
      emitted_q <= emitted_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hdr_we) begin
      hdr_q[hdr_idx] <= in_byte_i;
    end
  end

  always_comb begin
    pos_d     = pos_q;
    fill_d    = fill_q;
    rem_d     = rem_q;
    mode_d    = mode_q;
    keep_d    = keep_q;
    emitted_d = emitted_q;
    hdr_we    = 1'b0;
    hdr_idx   = fill_q;
    push_o    = '0;
    if (accept && (mode_q != rmcf_pkg::MODE_DONE)) begin
      if (pos_q >= file_length_q) begin
        // Byte beyond the file: close it in place of the byte
        push_o.valid       = 1'b1;
        push_o.cmd.has_end = 1'b1;
        push_o.cmd.status  = (mode_q == rmcf_pkg::MODE_FILE_HDR);
        push_o.cmd.total   = (mode_q == rmcf_pkg::MODE_FILE_HDR) ? 32'd0 : emitted_q;
        mode_d             = rmcf_pkg::MODE_DONE;
      end else begin
        unique case (mode_q)
          rmcf_pkg::MODE_FILE_HDR: begin
            hdr_we = 1'b1;
            fill_d = fill_q + 4'd1;
            if (fill_q == rmcf_pkg::LEN_FILE_HDR - 4'd1) begin
              fill_d = '0;
              if ((hdr_q[3:0] != rmcf_pkg::TAG_RIFF) ||
                  ({in_byte_i, hdr_q[10], hdr_q[9], hdr_q[8]} != rmcf_pkg::TAG_WEBP)) begin
                push_o.valid       = 1'b1;
                push_o.cmd.has_end = 1'b1;
                push_o.cmd.status  = 1'b1;
                mode_d             = rmcf_pkg::MODE_DONE;
              end else begin
                push_o.valid      = 1'b1;
                push_o.cmd.n_data = rmcf_pkg::LEN_FILE_HDR;
                push_o.cmd.data   = {in_byte_i, hdr_q[10:0]};
                emitted_d         = emitted_q + 32'd12;
                mode_d            = rmcf_pkg::MODE_CHUNK_HDR;
              end
            end
          end
          rmcf_pkg::MODE_CHUNK_HDR: begin
            hdr_we  = 1'b1;
            hdr_idx = {1'b0, fill_q[2:0]};
            fill_d  = fill_q + 4'd1;
            if (fill_q == rmcf_pkg::LEN_CHUNK_HDR - 4'd1) begin
              fill_d = '0;
              if (overrun) begin
                mode_d = rmcf_pkg::MODE_TRAIL;
              end else begin
                keep_d = keep_new;
                if (keep_new) begin
                  push_o.valid      = 1'b1;
                  push_o.cmd.n_data = rmcf_pkg::LEN_CHUNK_HDR;
                  push_o.cmd.data   = {32'd0, in_byte_i, hdr_q[6:0]};
                  emitted_d         = emitted_q + 32'd8;
                end
                rem_d  = padded;
                mode_d = (padded == 33'd0) ? rmcf_pkg::MODE_CHUNK_HDR
                                           : rmcf_pkg::MODE_PAYLOAD;
              end
            end
          end
          rmcf_pkg::MODE_PAYLOAD: begin
            if (keep_q) begin
              push_o.valid      = 1'b1;
              push_o.cmd.n_data = rmcf_pkg::LEN_BYTE;
              push_o.cmd.data   = {88'd0, in_byte_i};
              emitted_d         = emitted_q + 32'd1;
            end
            rem_d = rem_dec;
            if (rem_dec == 33'd0) begin
              mode_d = rmcf_pkg::MODE_CHUNK_HDR;
            end
          end
          default: ;
        endcase
        pos_d = pos_next;
        // Last byte of the file: append the end item to this step
        if ((pos_next == file_length_q) && (mode_d != rmcf_pkg::MODE_DONE)) begin
          push_o.valid       = 1'b1;
          push_o.cmd.has_end = 1'b1;
          push_o.cmd.status  = (mode_d == rmcf_pkg::MODE_FILE_HDR);
          push_o.cmd.total   = (mode_d == rmcf_pkg::MODE_FILE_HDR) ? 32'd0 : emitted_d;
          mode_d             = rmcf_pkg::MODE_DONE;
        end
      end
    end
  end

  a_file_hdr_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == rmcf_pkg::MODE_FILE_HDR) |-> (fill_q < rmcf_pkg::LEN_FILE_HDR))
    else $error("file header fill out of range");

  a_chunk_hdr_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == rmcf_pkg::MODE_CHUNK_HDR) |-> (fill_q < rmcf_pkg::LEN_CHUNK_HDR))
    else $error("chunk header fill out of range");

  a_payload_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == rmcf_pkg::MODE_PAYLOAD) |-> (rem_q != 33'd0))
    else $error("payload phase with nothing left");

endmodule
`default_nettype wire

[rtl/rmcf_queue.sv]
// Short command queue between the front end and the output sequencer.
`timescale 1ns / 1ps
`default_nettype none
module rmcf_queue #(
  parameter int unsigned Depth = 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire rmcf_pkg::cmd_req_t push_i,
  input  wire logic               pop_i,
  output logic                    full_o,
  output rmcf_pkg::cmd_req_t      head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  rmcf_pkg::cmd_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_pop;

  assign full_o       = (count_q == CntW'(Depth));
  assign head_o.valid = (count_q != '0);
  assign head_o.cmd   = mem_q[rd_ptr_q];
  assign do_pop       = pop_i && head_o.valid;

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i.valid) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i.valid && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i.valid && do_pop) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid |-> !full_o)
    else $error("push into a full queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count beyond depth");

endmodule
`default_nettype wire

[rtl/rmcf_back.sv]
// Output sequencer: expand each command into result transfers.
`timescale 1ns / 1ps
`default_nettype none
module rmcf_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire rmcf_pkg::cmd_req_t head_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    item_kind_o,
  output logic [7:0]              out_byte_o,
  output logic                    is_last_o,
  output logic [31:0]             total_length_o,
  output logic                    status_o
);

  logic [3:0] idx_q;
  logic [3:0] n_res;
  logic       load;
  logic       is_data;
  logic       final_res;

  assign n_res     = head_i.cmd.n_data + {3'b000, head_i.cmd.has_end};
  assign load      = head_i.valid && (!out_valid_o || out_ready_i);
  assign is_data   = (idx_q < head_i.cmd.n_data);
  assign final_res = ((idx_q + 4'd1) == n_res);
  assign pop_o     = load && final_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (load) begin
        out_valid_o <= 1'b1;
        idx_q       <= final_res ? 4'd0 : idx_q + 4'd1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_kind_o    <= !is_data;
      out_byte_o     <= is_data ? head_i.cmd.data[idx_q] : 8'd0;
      is_last_o      <= !is_data;
      total_length_o <= is_data ? 32'd0 : head_i.cmd.total;
      status_o       <= is_data ? 1'b0 : head_i.cmd.status;
    end
  end

  a_idx_in_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_i.valid |-> (idx_q < n_res))
    else $error("sequencer index past command");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (item_kind_o == is_last_o))
    else $error("end item and last flag disagree");

endmodule
`default_nettype wire

[rtl/riff_metadata_chunk_filter.sv]
// Top level of the RIFF/WebP metadata chunk filter.
// Takes a WebP file one byte per transfer (length in register file_length) and
// forwards it with EXIF and "XMP " chunks optionally dropped. The 12-byte file
// header must read RIFF....WEBP, otherwise no data goes out and a single end
// item with status 1 closes the file. Every kept chunk goes out whole, its
// 8-byte header first; a chunk whose padded payload would run past the file
// end discards everything from its header on. One end item follows the last
// byte and carries the number of bytes emitted; the RIFF size to patch
// downstream is that number minus 8. Rate: the front end takes one byte every
// cycle while the command queue has room; the output side gives one result
// transfer per cycle while the receiver takes them, so a header (12 or 8
// results for one byte, plus an end item) holds the output until all are out.
// Payload bytes pile up behind it one command each, at most twelve while the
// receiver keeps up, and the queue of QueueDepth commands (sixteen by default)
// absorbs that burst without stalling the input. A byte passes a queue entry
// and the output register. Configuration is to be written only while idle;
// strip flags are sampled when each chunk header completes, file_length on
// every byte. After the end item all bytes are taken and ignored until reset.
`timescale 1ns / 1ps
`default_nettype none
module riff_metadata_chunk_filter #(
  parameter int unsigned QueueDepth = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration writes
  input  wire logic                          cfg_we_i,
  input  wire logic [rmcf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [31:0]                   cfg_data_i,
  // byte input
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [7:0]                    in_byte_i,
  // result output
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               item_kind_o,
  output logic [7:0]                         out_byte_o,
  output logic                               is_last_o,
  output logic [31:0]                        total_length_o,
  output logic                               status_o
);

  rmcf_pkg::cmd_req_t push;
  rmcf_pkg::cmd_req_t head;
  logic               q_full;
  logic               pop;

  // Classify each byte and issue at most one command per transfer
  rmcf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .q_full_i    (q_full),
    .push_o      (push)
  );

  // Hold commands so that header bursts do not stall the input
  rmcf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .full_o (q_full),
    .head_o (head)
  );

  // Expand commands into result transfers through a registered output
  rmcf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .item_kind_o    (item_kind_o),
    .out_byte_o     (out_byte_o),
    .is_last_o      (is_last_o),
    .total_length_o (total_length_o),
    .status_o       (status_o)
  );

endmodule
`default_nettype wire
